[rtl/bgc_pkg.sv]
package bgc_pkg;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] neighbor;
    } t_req;

    typedef struct packed {
        logic       is_bipartite;
        logic [1:0] status;
    } t_res;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_CLOSE  = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_BAD_NB   = 2'd2;

    localparam logic [1:0] COL_NONE  = 2'd0;
    localparam logic [1:0] COL_FIRST = 2'd1;
    localparam logic [1:0] COL_SUM   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_CLR,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_ROOT_PUSH,
        S_WALK_A,
        S_WALK_B,
        S_WALK_C,
        S_WALK_D,
        S_WALK_E,
        S_WALK_F,
        S_NEXT
    } t_state;

endpackage

[rtl/bgc_ram.sv]
module bgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bipartite_graph_check.sv]
// Two-coloring check of a directed adjacency-list graph. A request is taken when i_start is
// high and o_busy is low. Append (op 0) and close (op 1) requests leave o_busy low, so
// loading runs at one request per cycle. A check request (op 2) gives one result, on o_res
// for the single cycle that o_done is high; the receiver cannot stall, so it must take it
// then. A check runs a range scan of the closed edges for bad neighbor indices, clears
// the colors of all vertices, then scans the vertices for uncolored roots and runs a
// depth-first walk from each, through the single read port of each memory. The walk
// stops early on the first same-color conflict, and a store overflow answers at once.
module bipartite_graph_check #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 8192
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bgc_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_done,
    output bgc_pkg::t_res o_res
);
    import bgc_pkg::*;

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int VCW  = $clog2(MAX_VERTICES + 1);
    localparam int EW   = $clog2(MAX_EDGES);
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int CMPW = (VCW > 10) ? VCW : 10;

    t_state          r_state, n_state;
    logic [VCW-1:0]  r_vert, n_vert;
    logic [ECW-1:0]  r_edges, n_edges;
    logic [ECW-1:0]  r_closed, n_closed;
    logic            r_ovf, n_ovf;
    logic [ECW-1:0]  r_eidx, n_eidx;
    logic [VCW-1:0]  r_vidx, n_vidx;
    logic [VCW-1:0]  r_depth, n_depth;
    logic [VW-1:0]   r_s, n_s;
    logic [ECW-1:0]  r_pos, n_pos;
    logic [1:0]      r_cs, n_cs;
    logic [VW-1:0]   r_t, n_t;
    logic            r_done, n_done;
    t_res            r_res, n_res;

    logic            edge_we;
    logic [EW-1:0]   edge_waddr, edge_raddr;
    logic [9:0]      edge_rdata;
    logic            le_we;
    logic [VW-1:0]   le_waddr, le_raddr;
    logic [ECW-1:0]  le_rdata;
    logic            col_we;
    logic [VW-1:0]   col_waddr, col_raddr;
    logic [1:0]      col_wdata, col_rdata;
    logic            sv_we;
    logic [VW-1:0]   sv_waddr, sv_wdata, sv_raddr, sv_rdata;
    logic            sp_we;
    logic [VW-1:0]   sp_waddr, sp_raddr;
    logic [ECW-1:0]  sp_wdata, sp_rdata;

    logic [VCW-1:0]  depth_m1, vidx_m1;
    logic [VW-1:0]   t_m1;
    logic [CMPW-1:0] nb_ext;
    logic            fin;
    t_res            fin_res;

    assign depth_m1 = r_depth - 1'b1;
    assign vidx_m1  = r_vidx - 1'b1;
    assign t_m1     = r_t - 1'b1;
    assign nb_ext   = CMPW'(edge_rdata);

    bgc_ram #(.WIDTH(10), .DEPTH(MAX_EDGES)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(i_req.neighbor),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );
    bgc_ram #(.WIDTH(ECW), .DEPTH(MAX_VERTICES)) u_list_end (
        .i_clk(i_clk), .i_we(le_we), .i_waddr(le_waddr), .i_wdata(r_edges),
        .i_raddr(le_raddr), .o_rdata(le_rdata)
    );
    bgc_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_color (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(col_waddr), .i_wdata(col_wdata),
        .i_raddr(col_raddr), .o_rdata(col_rdata)
    );
    bgc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack_vertex (
        .i_clk(i_clk), .i_we(sv_we), .i_waddr(sv_waddr), .i_wdata(sv_wdata),
        .i_raddr(sv_raddr), .o_rdata(sv_rdata)
    );
    bgc_ram #(.WIDTH(ECW), .DEPTH(MAX_VERTICES)) u_stack_pos (
        .i_clk(i_clk), .i_we(sp_we), .i_waddr(sp_waddr), .i_wdata(sp_wdata),
        .i_raddr(sp_raddr), .o_rdata(sp_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vert  <= '0;
            r_edges <= '0;
            r_closed <= '0;
            r_ovf   <= 1'b0;
            r_done  <= 1'b0;
            r_depth <= '0;
        end else begin
            r_state <= n_state;
            r_vert  <= n_vert;
            r_edges <= n_edges;
            r_closed <= n_closed;
            r_ovf   <= n_ovf;
            r_done  <= n_done;
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eidx <= n_eidx;
        r_vidx <= n_vidx;
        r_s    <= n_s;
        r_pos  <= n_pos;
        r_cs   <= n_cs;
        r_t    <= n_t;
        r_res  <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_vert   = r_vert;
        n_edges  = r_edges;
        n_closed = r_closed;
        n_ovf    = r_ovf;
        n_eidx   = r_eidx;
        n_vidx   = r_vidx;
        n_depth  = r_depth;
        n_s      = r_s;
        n_pos    = r_pos;
        n_cs     = r_cs;
        n_t      = r_t;
        n_done   = 1'b0;
        n_res    = r_res;
        fin      = 1'b0;
        fin_res  = '{is_bipartite: 1'b1, status: ST_OK};

        edge_we    = 1'b0;
        edge_waddr = r_edges[EW-1:0];
        edge_raddr = r_eidx[EW-1:0];
        le_we      = 1'b0;
        le_waddr   = r_vert[VW-1:0];
        le_raddr   = sv_rdata;
        col_we     = 1'b0;
        col_waddr  = r_vidx[VW-1:0];
        col_wdata  = COL_NONE;
        col_raddr  = r_vidx[VW-1:0];
        sv_we      = 1'b0;
        sv_waddr   = '0;
        sv_wdata   = r_vidx[VW-1:0];
        sv_raddr   = depth_m1[VW-1:0];
        sp_we      = 1'b0;
        sp_waddr   = '0;
        sp_wdata   = '0;
        sp_raddr   = depth_m1[VW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_req.op)
                        OP_APPEND: begin
                            if (r_vert >= VCW'(MAX_VERTICES) || r_edges >= ECW'(MAX_EDGES)) begin
                                n_ovf = 1'b1;
                            end else begin
                                edge_we = 1'b1;
                                n_edges = r_edges + 1'b1;
                            end
                        end
                        OP_CLOSE: begin
                            if (r_vert >= VCW'(MAX_VERTICES)) begin
                                n_ovf = 1'b1;
                            end else begin
                                le_we    = 1'b1;
                                n_vert   = r_vert + 1'b1;
                                n_closed = r_edges;
                            end
                        end
                        OP_CHECK: begin
                            if (r_ovf) begin
                                fin     = 1'b1;
                                fin_res = '{is_bipartite: 1'b0, status: ST_OVERFLOW};
                            end else begin
                                n_eidx  = '0;
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_eidx == r_closed) begin
                    n_vidx  = '0;
                    n_state = S_CLR;
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (nb_ext >= CMPW'(r_vert)) begin
                    fin     = 1'b1;
                    fin_res = '{is_bipartite: 1'b0, status: ST_BAD_NB};
                end else begin
                    n_eidx  = r_eidx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_CLR: begin
                if (r_vidx == r_vert) begin
                    n_vidx  = '0;
                    n_state = S_ROOT_RD;
                end else begin
                    col_we  = 1'b1;
                    n_vidx  = r_vidx + 1'b1;
                end
            end
            S_ROOT_RD: begin
                if (r_vidx == r_vert) begin
                    fin = 1'b1;
                end else begin
                    n_state = S_ROOT_CHK;
                end
            end
            S_ROOT_CHK: begin
                le_raddr = vidx_m1[VW-1:0];
                n_state  = (col_rdata == COL_NONE) ? S_ROOT_PUSH : S_NEXT;
            end
            S_ROOT_PUSH: begin
                col_we    = 1'b1;
                col_wdata = COL_FIRST;
                sv_we     = 1'b1;
                sp_we     = 1'b1;
                sp_wdata  = (r_vidx == '0) ? '0 : le_rdata;
                n_depth   = VCW'(1);
                n_state   = S_WALK_A;
            end
            S_WALK_A: begin
                n_state = S_WALK_B;
            end
            S_WALK_B: begin
                n_s       = sv_rdata;
                n_pos     = sp_rdata;
                col_raddr = sv_rdata;
                n_state   = S_WALK_C;
            end
            S_WALK_C: begin
                n_cs = col_rdata;
                if (r_pos >= le_rdata) begin
                    n_depth = depth_m1;
                    n_state = (r_depth == VCW'(1)) ? S_NEXT : S_WALK_A;
                end else begin
                    sp_we      = 1'b1;
                    sp_waddr   = depth_m1[VW-1:0];
                    sp_wdata   = r_pos + 1'b1;
                    edge_raddr = r_pos[EW-1:0];
                    n_state    = S_WALK_D;
                end
            end
            S_WALK_D: begin
                n_t       = nb_ext[VW-1:0];
                col_raddr = nb_ext[VW-1:0];
                n_state   = S_WALK_E;
            end
            S_WALK_E: begin
                le_raddr = t_m1;
                if (col_rdata == COL_NONE) begin
                    col_we    = 1'b1;
                    col_waddr = r_t;
                    col_wdata = COL_SUM - r_cs;
                    n_state   = (r_depth < VCW'(MAX_VERTICES)) ? S_WALK_F : S_WALK_A;
                end else if (col_rdata == r_cs) begin
                    fin     = 1'b1;
                    fin_res = '{is_bipartite: 1'b0, status: ST_OK};
                end else begin
                    n_state = S_WALK_A;
                end
            end
            S_WALK_F: begin
                sv_we    = 1'b1;
                sv_waddr = r_depth[VW-1:0];
                sv_wdata = r_t;
                sp_we    = 1'b1;
                sp_waddr = r_depth[VW-1:0];
                sp_wdata = (r_t == '0) ? '0 : le_rdata;
                n_depth  = r_depth + 1'b1;
                n_state  = S_WALK_A;
            end
            S_NEXT: begin
                n_vidx  = r_vidx + 1'b1;
                n_state = S_ROOT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_done   = 1'b1;
            n_res    = fin_res;
            n_vert   = '0;
            n_edges  = '0;
            n_closed = '0;
            n_ovf    = 1'b0;
            n_depth  = '0;
            n_state  = S_IDLE;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result while busy");
    a_fail_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != ST_OK) |-> !o_res.is_bipartite)
        else $error("flag set with error status");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start) && $past(i_req.op) == OP_CHECK)
        else $error("busy without check request");
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= VCW'(MAX_VERTICES))
        else $error("stack depth out of range");
`endif

endmodule
